// ----- sv/pbcd_pkg.sv -----
`timescale 1ns / 1ps

package pbcd_pkg;

  // Digit counts, digit positions and the scale all fit the 6-bit register width.
  localparam int CNT_W = 6;

  // Configuration register indexes.
  localparam logic REG_PRECISION = 1'b0;
  localparam logic REG_SCALE     = 1'b1;

  // Number of finished values that may wait for the back end (one digit bank each).
  localparam int QDEPTH = 2;

  // One finished value, handed from the front end to the back end.
  typedef struct packed {
    logic             err;
    logic [CNT_W-1:0] n;
    logic [CNT_W-1:0] scale;
    logic             neg;
    logic [CNT_W-1:0] lnz;
    logic             bank;
  } job_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ERR,
    S_LEN_HI,
    S_LEN_LO,
    S_EXPO,
    S_BCD
  } bk_state_t;

endpackage

// ----- sv/pbcd_front.sv -----
`timescale 1ns / 1ps

module pbcd_front #(
  parameter int MAX_DIGITS = 32,
  localparam int AW = $clog2(MAX_DIGITS),
  localparam int MW = AW + 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [5:0]            cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [3:0]            digit,
  input  logic                  is_negative,
  input  logic                  q_full,
  output logic                  push,
  output pbcd_pkg::job_t        job,
  output logic                  wr_en,
  output logic [MW-1:0]         wr_addr,
  output logic [3:0]            wr_data
);

  localparam logic [pbcd_pkg::CNT_W:0] MAX_N = (pbcd_pkg::CNT_W + 1)'(MAX_DIGITS);

  logic [pbcd_pkg::CNT_W-1:0] precision;
  logic [pbcd_pkg::CNT_W-1:0] scale;
  logic [pbcd_pkg::CNT_W-1:0] count;
  logic                       sign_latch;
  logic [pbcd_pkg::CNT_W-1:0] lnz;
  logic                       bank;

  logic [3:0]                 d_sat;
  logic [pbcd_pkg::CNT_W:0]   prec_ext;
  logic                       over_max;
  logic                       bad;
  logic [pbcd_pkg::CNT_W-1:0] n;
  logic                       accept;
  logic                       store;
  logic [pbcd_pkg::CNT_W-1:0] cnt_after;
  logic                       sign_next;
  logic [pbcd_pkg::CNT_W-1:0] lnz_next;
  logic                       done;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  assign d_sat    = (digit > 4'd9) ? 4'd9 : digit;
  assign prec_ext = {1'b0, precision};
  assign over_max = prec_ext > MAX_N;
  assign bad      = (precision == '0) || over_max;

  always_comb begin
    priority if (precision == '0) begin
      n = pbcd_pkg::CNT_W'(1);
    end else if (over_max) begin
      n = MAX_N[pbcd_pkg::CNT_W-1:0];
    end else begin
      n = precision;
    end
  end

  // A precision lowered mid-value can finish the value without taking the digit.
  assign store     = count < n;
  assign cnt_after = store ? count + pbcd_pkg::CNT_W'(1) : count;
  assign done      = cnt_after >= n;
  assign sign_next = (store && count == '0) ? is_negative : sign_latch;

  always_comb begin
    priority if (!store) begin
      lnz_next = lnz;
    end else if (d_sat != 4'd0) begin
      lnz_next = count + pbcd_pkg::CNT_W'(1);
    end else if (count == '0) begin
      lnz_next = '0;
    end else begin
      lnz_next = lnz;
    end
  end

  assign push      = accept && done;
  assign job.err   = bad || (scale > precision);
  assign job.n     = n;
  assign job.scale = scale;
  assign job.neg   = sign_next;
  assign job.lnz   = lnz_next;
  assign job.bank  = bank;

  assign wr_en   = accept && store;
  assign wr_addr = {count[AW-1:0], bank};
  assign wr_data = d_sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      precision  <= pbcd_pkg::CNT_W'(1);
      scale      <= '0;
      count      <= '0;
      sign_latch <= 1'b0;
      lnz        <= '0;
      bank       <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          pbcd_pkg::REG_PRECISION: precision <= cfg_data;
          pbcd_pkg::REG_SCALE:     scale     <= cfg_data;
        endcase
      end
      if (accept) begin
        sign_latch <= sign_next;
        lnz        <= lnz_next;
        count      <= done ? '0 : cnt_after;
        if (done) begin
          bank <= ~bank;
        end
      end
    end
  end

endmodule

// ----- sv/pbcd_jobq.sv -----
`timescale 1ns / 1ps

module pbcd_jobq (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  pbcd_pkg::job_t din,
  output logic           full,
  output logic           q_valid,
  output pbcd_pkg::job_t head,
  input  logic           pop
);

  localparam logic [1:0] DEPTH = 2'(pbcd_pkg::QDEPTH);

  pbcd_pkg::job_t slots [pbcd_pkg::QDEPTH];
  logic           wptr;
  logic           rptr;
  logic [1:0]     count;

  assign full    = count == DEPTH;
  assign q_valid = count != 2'd0;
  assign head    = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ----- sv/pbcd_back.sv -----
`timescale 1ns / 1ps

module pbcd_back #(
  parameter int MAX_DIGITS = 32,
  localparam int AW = $clog2(MAX_DIGITS),
  localparam int MW = AW + 1
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_en,
  input  logic [MW-1:0]  wr_addr,
  input  logic [3:0]     wr_data,
  input  logic           q_valid,
  input  pbcd_pkg::job_t job,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [7:0]     out_byte,
  output logic           last_byte,
  output logic           error
);

  localparam int KW = pbcd_pkg::CNT_W + 1;
  localparam logic [KW-1:0] MAX_K = KW'(MAX_DIGITS);

  // Two banks of digits, interleaved on the lowest address bit.
  logic [3:0] mem [2*MAX_DIGITS];

  pbcd_pkg::bk_state_t state;
  pbcd_pkg::bk_state_t state_next;

  logic [pbcd_pkg::CNT_W-1:0] bidx;
  logic [pbcd_pkg::CNT_W-1:0] bidx_next;
  logic [3:0]                 rd_hi;
  logic [3:0]                 rd_lo;
  logic [KW-1:0]              rd_k;

  logic                       out_free;
  logic                       load;
  logic [7:0]                 ld_byte;
  logic                       ld_last;
  logic                       ld_err;
  logic                       rd_en;
  logic [pbcd_pkg::CNT_W-1:0] rd_i;
  logic [KW-1:0]              k0;
  logic [KW-1:0]              k1;
  logic [MW-1:0]              a0;
  logic [MW-1:0]              a1;

  logic [KW-1:0]              n_p1;
  logic [pbcd_pkg::CNT_W-1:0] bcd_len;
  logic [7:0]                 len_lo;
  logic [6:0]                 expo_mag;
  logic [7:0]                 expo;
  logic [3:0]                 hi_nib;
  logic [3:0]                 lo_nib;
  logic                       bcd_last;

  // Digits of a negative value are complemented up to and including the
  // lowest nonzero one; the pad nibble always stays zero.
  function automatic logic [3:0] nib_val(input logic [3:0] d, input logic [KW-1:0] k,
                                         input logic [pbcd_pkg::CNT_W-1:0] n,
                                         input logic [pbcd_pkg::CNT_W-1:0] lnz,
                                         input logic neg);
    logic [KW-1:0] kp1;
    logic [KW-1:0] lnz_ext;
    kp1     = k + KW'(1);
    lnz_ext = {1'b0, lnz};
    if (k >= {1'b0, n}) return 4'd0;
    if (!neg || lnz == '0 || kp1 > lnz_ext) return d;
    if (kp1 == lnz_ext) return 4'd10 - d;
    return 4'd9 - d;
  endfunction

  assign n_p1     = {1'b0, job.n} + KW'(1);
  assign bcd_len  = n_p1[KW-1:1];
  assign len_lo   = {2'b00, bcd_len} + 8'd1;
  assign expo_mag = {1'b0, job.n} + 7'd63 - {1'b0, job.scale};
  assign expo     = {~job.neg, expo_mag};

  assign hi_nib   = nib_val(rd_hi, rd_k, job.n, job.lnz, job.neg);
  assign lo_nib   = nib_val(rd_lo, rd_k + KW'(1), job.n, job.lnz, job.neg);
  assign bcd_last = (bidx + pbcd_pkg::CNT_W'(1)) == bcd_len;

  assign out_free = !out_valid || out_ready;

  assign k0 = {rd_i, 1'b0};
  assign k1 = {rd_i, 1'b1};
  assign a0 = {k0[AW-1:0], job.bank};
  assign a1 = (k1 < MAX_K) ? {k1[AW-1:0], job.bank} : '0;

  always_comb begin
    state_next = state;
    unique case (state)
      pbcd_pkg::S_IDLE: begin
        if (q_valid) begin
          state_next = job.err ? pbcd_pkg::S_ERR : pbcd_pkg::S_LEN_HI;
        end
      end
      pbcd_pkg::S_ERR: begin
        if (out_free) state_next = pbcd_pkg::S_IDLE;
      end
      pbcd_pkg::S_LEN_HI: begin
        if (out_free) state_next = pbcd_pkg::S_LEN_LO;
      end
      pbcd_pkg::S_LEN_LO: begin
        if (out_free) state_next = pbcd_pkg::S_EXPO;
      end
      pbcd_pkg::S_EXPO: begin
        if (out_free) state_next = pbcd_pkg::S_BCD;
      end
      pbcd_pkg::S_BCD: begin
        if (out_free && bcd_last) state_next = pbcd_pkg::S_IDLE;
      end
      default: state_next = pbcd_pkg::S_IDLE;
    endcase
  end

  // The read for the next packed byte goes out in the cycle the current byte
  // is loaded, so packed bytes leave one per cycle while the output is not stalled.
  always_comb begin
    load      = 1'b0;
    ld_byte   = 8'd0;
    ld_last   = 1'b0;
    ld_err    = 1'b0;
    rd_en     = 1'b0;
    rd_i      = '0;
    q_pop     = 1'b0;
    bidx_next = bidx;
    unique case (state)
      pbcd_pkg::S_IDLE: begin
      end
      pbcd_pkg::S_ERR: begin
        if (out_free) begin
          load    = 1'b1;
          ld_last = 1'b1;
          ld_err  = 1'b1;
          q_pop   = 1'b1;
        end
      end
      pbcd_pkg::S_LEN_HI: begin
        if (out_free) begin
          load = 1'b1;
        end
      end
      pbcd_pkg::S_LEN_LO: begin
        if (out_free) begin
          load    = 1'b1;
          ld_byte = len_lo;
        end
      end
      pbcd_pkg::S_EXPO: begin
        if (out_free) begin
          load      = 1'b1;
          ld_byte   = expo;
          rd_en     = 1'b1;
          bidx_next = '0;
        end
      end
      pbcd_pkg::S_BCD: begin
        if (out_free) begin
          load    = 1'b1;
          ld_byte = {hi_nib, lo_nib};
          ld_last = bcd_last;
          if (bcd_last) begin
            q_pop = 1'b1;
          end else begin
            rd_en     = 1'b1;
            rd_i      = bidx + pbcd_pkg::CNT_W'(1);
            bidx_next = bidx + pbcd_pkg::CNT_W'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_hi <= mem[a0];
      rd_lo <= mem[a1];
      rd_k  <= k0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pbcd_pkg::S_IDLE;
      bidx  <= '0;
    end else begin
      state <= state_next;
      bidx  <= bidx_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte  <= ld_byte;
      last_byte <= ld_last;
      error     <= ld_err;
    end
  end

  a_err_beat: assert property (@(posedge clk) disable iff (rst)
    out_valid && error |-> last_byte && out_byte == 8'h00)
    else $error("error beat without last flag or with nonzero byte");

  a_pop_state: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> state == pbcd_pkg::S_ERR || state == pbcd_pkg::S_BCD)
    else $error("value released before its record was sent");

  a_bidx_range: assert property (@(posedge clk) disable iff (rst)
    state == pbcd_pkg::S_BCD |-> bidx < bcd_len)
    else $error("packed byte index ran past the record");

  a_job_held: assert property (@(posedge clk) disable iff (rst)
    state != pbcd_pkg::S_IDLE |-> q_valid)
    else $error("record in progress without a queued value");

endmodule

// ----- sv/packed_bcd_decimal_encoder.sv -----
`timescale 1ns / 1ps

// Channel   Beat                         Handshake
// config    precision / scale write      cfg_we, cfg_index, cfg_data
// input     digit, is_negative           in_valid / in_ready
// output    out_byte, last_byte, error   out_valid / out_ready
//
// One digit beat is taken per cycle while fewer than two finished values wait
// for the back end; each finished value holds one of two digit banks.
// A record of p digits leaves as 3 + ceil(p/2) beats, one per cycle while the
// output is not stalled; an error leaves as one beat.
// Reset is synchronous: precision 1, scale 0, no partial value, queue empty.
// A stalled output holds the back end; digits still fill the free bank, then stop.

module packed_bcd_decimal_encoder #(
  parameter int MAX_DIGITS = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [5:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [3:0] digit,
  input  logic       is_negative,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       last_byte,
  output logic       error
);

  localparam int MW = $clog2(MAX_DIGITS) + 1;

  logic           q_full;
  logic           push;
  pbcd_pkg::job_t job_in;
  logic           q_valid;
  pbcd_pkg::job_t job_head;
  logic           q_pop;
  logic           wr_en;
  logic [MW-1:0]  wr_addr;
  logic [3:0]     wr_data;

  pbcd_front #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .digit      (digit),
    .is_negative(is_negative),
    .q_full     (q_full),
    .push       (push),
    .job        (job_in),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data)
  );

  pbcd_jobq u_jobq (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .din    (job_in),
    .full   (q_full),
    .q_valid(q_valid),
    .head   (job_head),
    .pop    (q_pop)
  );

  pbcd_back #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .q_valid  (q_valid),
    .job      (job_head),
    .q_pop    (q_pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_byte (out_byte),
    .last_byte(last_byte),
    .error    (error)
  );

endmodule

// ----- tb/packed_bcd_decimal_encoder_checker.sv -----
`timescale 1ns / 1ps

module packed_bcd_decimal_encoder_checker #(
  parameter int MAX_DIGITS = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [5:0] cfg_data,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [3:0] digit,
  input  logic       is_negative,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] out_byte,
  input  logic       last_byte,
  input  logic       error,
  output int         fail_count,
  output int         pending,
  output int         beats_checked,
  output int         records_checked
);

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       err;
  } wire_beat_t;

  wire_beat_t  record_queue[$];
  wire_beat_t  want;
  logic [3:0]  held_digits[MAX_DIGITS];
  int unsigned held_count;
  int unsigned low_nz_pos;
  logic        neg_latch;
  logic [5:0]  precision_reg;
  logic [5:0]  scale_reg;

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    fail_count++;
  endtask

  task automatic push_beat(input logic [7:0] data, input logic last, input logic err);
    wire_beat_t b;
    b.data = data;
    b.last = last;
    b.err  = err;
    record_queue.push_back(b);
  endtask

  // Nibble k of the packed string, complemented for a negative value. Digits
  // below the lowest nonzero one stay zero, which keeps the carry chain implicit.
  function automatic logic [3:0] bcd_nibble(input int unsigned k, input int unsigned n);
    logic [3:0] d;
    if (k >= n) return 4'd0;
    d = held_digits[k];
    if (!neg_latch || low_nz_pos == 0 || k + 1 > low_nz_pos) return d;
    if (k + 1 == low_nz_pos) return 4'd10 - d;
    return 4'd9 - d;
  endfunction

  task automatic take_digit(input logic [3:0] raw, input logic neg);
    logic [3:0]  d;
    int unsigned n;
    int unsigned nbytes;
    int unsigned expo;
    logic        bad;
    d = (raw > 4'd9) ? 4'd9 : raw;
    n = precision_reg;
    bad = 1'b0;
    if (n == 0) begin
      n = 1;
      bad = 1'b1;
    end else if (n > MAX_DIGITS) begin
      n = MAX_DIGITS;
      bad = 1'b1;
    end
    // The precision is read on every beat, so a lowered precision can
    // complete a value without storing the digit of this beat.
    if (held_count < n) begin
      if (held_count == 0) begin
        neg_latch = neg;
        low_nz_pos = 0;
      end
      held_digits[held_count] = d;
      if (d != 0) low_nz_pos = held_count + 1;
      held_count++;
    end
    if (held_count < n) return;
    held_count = 0;
    if (bad || scale_reg > precision_reg) begin
      push_beat(8'h00, 1'b1, 1'b1);
      return;
    end
    nbytes = (n + 1) / 2;
    expo = ((n - scale_reg - 1 + 64) & 32'h7F) | (neg_latch ? 32'h0 : 32'h80);
    push_beat(8'((1 + nbytes) >> 8), 1'b0, 1'b0);
    push_beat(8'(1 + nbytes), 1'b0, 1'b0);
    push_beat(8'(expo), 1'b0, 1'b0);
    for (int i = 0; i < nbytes; i++)
      push_beat({bcd_nibble(2 * i, n), bcd_nibble(2 * i + 1, n)}, (i + 1 == nbytes), 1'b0);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      record_queue.delete();
      for (int i = 0; i < MAX_DIGITS; i++) held_digits[i] = 4'd0;
      held_count = 0;
      low_nz_pos = 0;
      neg_latch = 1'b0;
      precision_reg = 6'd1;
      scale_reg = 6'd0;
      fail_count = 0;
      beats_checked = 0;
      records_checked = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (record_queue.size() == 0) begin
          report_mismatch($sformatf("beat %02h last %b error %b with nothing expected",
                                    out_byte, last_byte, error));
        end else begin
          want = record_queue.pop_front();
          if (out_byte !== want.data)
            report_mismatch($sformatf("out_byte %02h, expected %02h", out_byte, want.data));
          if (last_byte !== want.last)
            report_mismatch($sformatf("last_byte %b, expected %b", last_byte, want.last));
          if (error !== want.err)
            report_mismatch($sformatf("error %b, expected %b", error, want.err));
          beats_checked++;
          if (want.last) records_checked++;
        end
      end
      if (cfg_we) begin
        if (cfg_index == pbcd_pkg::REG_PRECISION) precision_reg = cfg_data;
        else scale_reg = cfg_data;
      end
      if (in_valid && in_ready) take_digit(digit, is_negative);
    end
    pending = record_queue.size();
  end

endmodule

// ----- tb/packed_bcd_decimal_encoder_tb.sv -----
`timescale 1ns / 1ps

module packed_bcd_decimal_encoder_tb;

  localparam int MAX_DIGITS    = 32;
  localparam int RANDOM_DIGITS = 250;
  localparam int QUIET_DIGITS  = 50;
  localparam int SETTLE_CYCLES = 12;
  localparam int CYCLE_LIMIT   = 300000;

  logic       clk;
  logic       rst;
  logic       cfg_we;
  logic       cfg_index;
  logic [5:0] cfg_data;
  logic       in_valid;
  logic       in_ready;
  logic [3:0] digit;
  logic       is_negative;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic       last_byte;
  logic       error;

  int fail_count;
  int pending;
  int beats_checked;
  int records_checked;

  // Zero turns idling off; otherwise a burst starts with odds one in gap_odds.
  int gap_odds = 0;
  int stall_left = 0;
  int cycle_count = 0;
  int digits_sent = 0;
  int configs_loaded = 0;
  logic [5:0] cur_precision;
  logic [5:0] cur_scale;

  packed_bcd_decimal_encoder #(.MAX_DIGITS(MAX_DIGITS)) DUT (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .digit(digit), .is_negative(is_negative),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_byte(out_byte), .last_byte(last_byte), .error(error)
  );

  packed_bcd_decimal_encoder_checker #(.MAX_DIGITS(MAX_DIGITS)) record_check (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .digit(digit), .is_negative(is_negative),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_byte(out_byte), .last_byte(last_byte), .error(error),
    .fail_count(fail_count), .pending(pending),
    .beats_checked(beats_checked), .records_checked(records_checked)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats still expected", cycle_count, pending);
      $display("** packed_bcd_decimal_encoder: FAILED **");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (stall_left == 0 && gap_odds != 0 && $urandom_range(gap_odds - 1, 0) == 0)
      stall_left = $urandom_range(9, 1);
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic int value_len();
    if (cur_precision == 0) return 1;
    if (cur_precision > MAX_DIGITS) return MAX_DIGITS;
    return int'(cur_precision);
  endfunction

  // Zeros are common so that the lowest nonzero digit moves around;
  // digits above nine are rarer noise that must saturate.
  function automatic logic [3:0] pick_digit();
    int r;
    r = $urandom_range(99, 0);
    if (r < 30) return 4'd0;
    if (r < 38) return 4'($urandom_range(15, 10));
    return 4'($urandom_range(9, 1));
  endfunction

  task automatic send_digit(input logic [3:0] d, input logic neg);
    if (gap_odds != 0 && $urandom_range(gap_odds - 1, 0) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(9, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    digit <= d;
    is_negative <= neg;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    digits_sent++;
  endtask

  // The sign only matters on the first beat; later beats carry a random one.
  task automatic send_value(input int count, input logic neg);
    for (int i = 0; i < count; i++)
      send_digit(pick_digit(), (i == 0) ? neg : 1'($urandom_range(1, 0)));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_config(input logic [5:0] p, input logic [5:0] s);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_index <= pbcd_pkg::REG_PRECISION;
    cfg_data <= p;
    @(posedge clk);
    cfg_index <= pbcd_pkg::REG_SCALE;
    cfg_data <= s;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_precision = p;
    cur_scale = s;
    configs_loaded++;
  endtask

  initial begin
    int start;
    int r;
    int nvals;
    logic [5:0] p;
    logic [5:0] s;

    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= pbcd_pkg::REG_PRECISION;
    cfg_data <= 6'd0;
    in_valid <= 1'b0;
    digit <= 4'd0;
    is_negative <= 1'b0;
    cur_precision = 6'd1;
    cur_scale = 6'd0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Reset setting, one digit per value: zero, nine, a saturated digit, negative zero.
    send_digit(4'd0, 1'b0);
    send_digit(4'd9, 1'b1);
    send_digit(4'd15, 1'b1);
    send_digit(4'd0, 1'b1);

    load_config(6'd2, 6'd1);
    send_digit(4'd1, 1'b1);
    send_digit(4'd0, 1'b0);
    send_digit(4'd0, 1'b1);
    send_digit(4'd1, 1'b1);
    send_digit(4'd9, 1'b0);
    send_digit(4'd9, 1'b1);

    // Scale equal to an odd precision; the pad nibble stays zero under the complement.
    load_config(6'd7, 6'd7);
    for (int i = 0; i < 7; i++) send_digit(4'(i + 1), (i == 0));

    load_config(6'd0, 6'd0);
    send_digit(4'd5, 1'b0);

    // Precision above the digit store: a full store of digits, then an error.
    load_config(6'd63, 6'd0);
    send_value(value_len(), 1'b1);

    load_config(6'd3, 6'd63);
    send_value(value_len(), 1'b0);
    load_config(6'd5, 6'd6);
    send_value(value_len(), 1'b1);

    // Precision lowered below the digits held: the next beat closes the value.
    load_config(6'd6, 6'd2);
    send_value(4, 1'b1);
    load_config(6'd3, 6'd2);
    send_digit(4'd7, 1'b0);
    // Precision raised mid-value: the value simply runs longer.
    load_config(6'd4, 6'd2);
    send_value(2, 1'b1);
    load_config(6'd7, 6'd2);
    send_value(5, 1'b0);

    start = digits_sent;
    while (digits_sent - start < RANDOM_DIGITS) begin
      if (digits_sent - start > RANDOM_DIGITS - QUIET_DIGITS) gap_odds = 0;
      else gap_odds = ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(8, 3);

      r = $urandom_range(19, 0);
      if (r < 12) begin
        p = 6'($urandom_range(8, 1));
        s = 6'($urandom_range(p, 0));
      end else if (r < 14) begin
        p = 6'($urandom_range(31, 9));
        s = 6'($urandom_range(p, 0));
      end else if (r == 14) begin
        p = 6'd32;
        s = 6'($urandom_range(32, 0));
      end else if (r == 15) begin
        p = 6'($urandom_range(8, 1));
        s = 6'($urandom_range(63, p + 1));
      end else if (r == 16) begin
        p = 6'd0;
        s = 6'($urandom_range(63, 0));
      end else if (r == 17) begin
        p = 6'($urandom_range(63, 33));
        s = 6'($urandom_range(63, 0));
      end else begin
        p = 6'($urandom_range(12, 1));
        s = p;
      end
      load_config(p, s);

      nvals = (value_len() > 8) ? 1 : $urandom_range(5, 2);
      for (int v = 0; v < nvals; v++) send_value(value_len(), 1'($urandom_range(1, 0)));
      // Sometimes leave a value unfinished so the next setting lands mid-value.
      if (value_len() > 1 && $urandom_range(5, 0) == 0)
        send_value($urandom_range(value_len() - 1, 1), 1'($urandom_range(1, 0)));
    end

    gap_odds = 0;
    wait_drained();
    $display("sent %0d digit beats under %0d settings; checked %0d output beats in %0d records",
             digits_sent, configs_loaded, beats_checked, records_checked);
    $display("settings spanned precision 0 to 63 and scale 0 to 63, with mid-value changes");
    if (fail_count == 0 && pending == 0) begin
      $display("** packed_bcd_decimal_encoder: PASSED **");
    end else begin
      $display("** packed_bcd_decimal_encoder: FAILED **");
    end
    $finish;
  end

endmodule

// ----- packed_bcd_decimal_encoder.f -----
sv/pbcd_pkg.sv
sv/pbcd_front.sv
sv/pbcd_jobq.sv
sv/pbcd_back.sv
sv/packed_bcd_decimal_encoder.sv
tb/packed_bcd_decimal_encoder_checker.sv
tb/packed_bcd_decimal_encoder_tb.sv
